>>> hw/rtl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Types and constants shared by the channel id converter: field widths,
// register indexes, register reset values and the pipeline item layout.
// ----------------------------------------------------------------------------
package dcc_pkg;

  // field widths
  localparam int ABS_W  = 21;
  localparam int MOD_W  = 4;
  localparam int GRID_W = 8;
  localparam int CELL_W = 2 * GRID_W;   // cells of one grid in one module
  localparam int TOT_W  = 20;           // cells of one kind over all modules
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLUMNS     = 3'd4;

  // opcodes
  localparam logic OP_ABS_TO_REL = 1'b0;
  localparam logic OP_REL_TO_ABS = 1'b1;

  // register reset values
  localparam int RST_MODULE_COUNT    = 5;
  localparam int RST_CRYSTAL_ROWS    = 64;
  localparam int RST_CRYSTAL_COLUMNS = 56;
  localparam int RST_PAD_ROWS        = 128;
  localparam int RST_PAD_COLUMNS     = 60;

  // derived geometry at reset
  localparam int RST_CRY_PER_MOD = RST_CRYSTAL_ROWS * RST_CRYSTAL_COLUMNS;
  localparam int RST_PAD_PER_MOD = RST_PAD_ROWS * RST_PAD_COLUMNS;
  localparam int RST_CRY_TOTAL   = RST_MODULE_COUNT * RST_CRY_PER_MOD;
  localparam int RST_PAD_TOTAL   = RST_MODULE_COUNT * RST_PAD_PER_MOD;
  localparam int RST_ALL_TOTAL   = RST_CRY_TOTAL + RST_PAD_TOTAL;

  // pipeline depth
  localparam int NUM_STAGES = 10;

  // geometry registers and their registered products
  typedef struct packed {
    logic [MOD_W-1:0]  module_count;
    logic [GRID_W-1:0] crystal_rows;
    logic [GRID_W-1:0] crystal_columns;
    logic [GRID_W-1:0] pad_rows;
    logic [GRID_W-1:0] pad_columns;
    logic [CELL_W-1:0] cry_per_mod;
    logic [CELL_W-1:0] pad_per_mod;
    logic [TOT_W-1:0]  cry_total;
    logic [TOT_W-1:0]  pad_total;
    logic [ABS_W-1:0]  all_total;
  } geom_t;

  // one item as it moves down the pipeline
  typedef struct packed {
    logic              opcode;
    logic [ABS_W-1:0]  abs_id;
    logic [MOD_W-1:0]  module_id;
    logic              veto;
    logic [GRID_W-1:0] row;
    logic [GRID_W-1:0] column;
    logic              oor;
    logic [TOT_W-1:0]  prod_mod;
    logic [CELL_W-1:0] prod_row;
    logic [ABS_W-1:0]  rem;
    logic [CELL_W-1:0] div_mod;
    logic [GRID_W-1:0] div_col;
    logic [MOD_W-1:0]  q_mod;
    logic [GRID_W-1:0] q_row;
    logic [ABS_W-1:0]  abs_id_out;
    logic [GRID_W-1:0] module_out;
    logic              veto_out;
    logic [GRID_W-1:0] row_out;
    logic [GRID_W-1:0] column_out;
  } pipe_t;

  // two restoring division steps
  typedef struct packed {
    logic [ABS_W-1:0] rem;
    logic [1:0]       q;
  } div_t;

endpackage

>>> hw/rtl/dcc_if.sv
// ----------------------------------------------------------------------------
// dcc_req_if / dcc_rsp_if
// Valid/ready channels of the channel id converter: request items in,
// result items out.
// ----------------------------------------------------------------------------
interface dcc_req_if;
  import dcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ABS_W-1:0]  abs_id_in;
  logic [MOD_W-1:0]  module_in;
  logic              veto_in;
  logic [GRID_W-1:0] row_in;
  logic [GRID_W-1:0] column_in;

  modport source (
    output valid, opcode, abs_id_in, module_in, veto_in, row_in, column_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, abs_id_in, module_in, veto_in, row_in, column_in,
    output ready
  );
endinterface

interface dcc_rsp_if;
  import dcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ABS_W-1:0]  abs_id_out;
  logic [GRID_W-1:0] module_out;
  logic              veto_out;
  logic [GRID_W-1:0] row_out;
  logic [GRID_W-1:0] column_out;
  logic              out_of_range;

  modport source (
    output valid, abs_id_out, module_out, veto_out, row_out, column_out,
           out_of_range,
    input  ready
  );
  modport sink (
    input  valid, abs_id_out, module_out, veto_out, row_out, column_out,
           out_of_range,
    output ready
  );
endinterface

>>> hw/rtl/detector_channel_id_converter.sv
// ----------------------------------------------------------------------------
// detector_channel_id_converter
// Converts calorimeter channel numbers between a flat 1-based id and a
// (module, crystal or veto pad, row, column) tuple, with a range flag.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: opcode 0 splits abs_id_in into a
//   tuple, opcode 1 builds an id from module_in, veto_in, row_in, column_in.
//   rsp returns exactly one item per request, in order; out_of_range marks
//   ids or tuples outside the configured grid, with the result fields zero.
//   The geometry registers are written through cfg_we / cfg_index / cfg_data
//   while no item is in flight; registers beyond the list ignore writes.
// Timing:
//   one item per cycle is sustained while rsp.ready stays high.
//   The depth is set by the restoring divider: four quotient bits for the
//   module and eight for the row, two bits per stage.
// Reset:
//   rst empties the pipeline and loads the default geometry.
// Stall:
//   when rsp.ready is low the last stage holds and the stages behind it keep
//   filling their empty slots; req.ready drops only when all ten stages hold
//   an item.
// ----------------------------------------------------------------------------
module detector_channel_id_converter (
  input  logic                             clk,
  input  logic                             rst,
  dcc_req_if.sink                          req,
  dcc_rsp_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [dcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dcc_pkg::*;

  localparam int N = NUM_STAGES;

  geom_t          geom;
  pipe_t          p   [N];
  pipe_t          nxt [N];
  logic [N-1:0]   v;
  logic [N-1:0]   adv;

  // two restoring steps at quotient bits sh and sh-1
  function automatic div_t div2(input logic [ABS_W-1:0] rem,
                                input logic [CELL_W-1:0] d,
                                input int unsigned sh);
    logic [ABS_W-1:0] r;
    logic [ABS_W-1:0] dh;
    logic [ABS_W-1:0] dl;
    div_t             res;
    r  = rem;
    dh = {{(ABS_W-CELL_W){1'b0}}, d} << sh;
    dl = {{(ABS_W-CELL_W){1'b0}}, d} << (sh - 1);
    res.q = 2'b00;
    if (r >= dh) begin
      r = r - dh;
      res.q[1] = 1'b1;
    end
    if (r >= dl) begin
      r = r - dl;
      res.q[0] = 1'b1;
    end
    res.rem = r;
    return res;
  endfunction

  dcc_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // stage 0: capture the request
  always_comb begin
    nxt[0]           = '0;
    nxt[0].opcode    = req.opcode;
    nxt[0].abs_id    = req.abs_id_in;
    nxt[0].module_id = req.module_in;
    nxt[0].veto      = req.veto_in;
    nxt[0].row       = req.row_in;
    nxt[0].column    = req.column_in;
  end

  // stage 1: tuple range check and the two products of the id
  always_comb begin : st1
    logic [GRID_W-1:0] rows;
    logic [GRID_W-1:0] cols;
    logic [CELL_W-1:0] per_mod;
    logic [MOD_W-1:0]  mod_m1;
    logic [GRID_W-1:0] row_m1;
    rows    = p[0].veto ? geom.pad_rows : geom.crystal_rows;
    cols    = p[0].veto ? geom.pad_columns : geom.crystal_columns;
    per_mod = p[0].veto ? geom.pad_per_mod : geom.cry_per_mod;
    mod_m1  = p[0].module_id - MOD_W'(1);
    row_m1  = p[0].row - GRID_W'(1);
    nxt[1]  = p[0];
    if (p[0].opcode == OP_REL_TO_ABS) begin
      nxt[1].oor = (p[0].module_id == '0) || (p[0].module_id > geom.module_count)
                   || (p[0].row == '0) || (p[0].row > rows)
                   || (p[0].column == '0) || (p[0].column > cols);
    end
    nxt[1].prod_mod = {{(TOT_W-MOD_W){1'b0}}, mod_m1}
                      * {{(TOT_W-CELL_W){1'b0}}, per_mod};
    nxt[1].prod_row = {{GRID_W{1'b0}}, row_m1} * {{GRID_W{1'b0}}, cols};
  end

  // stage 2: sum of the id; kind split and divisors for the tuple
  always_comb begin : st2
    logic [ABS_W-1:0] base;
    logic [ABS_W-1:0] cry_tot;
    logic             is_pad;
    cry_tot = {1'b0, geom.cry_total};
    base    = p[1].veto ? cry_tot : '0;
    is_pad  = p[1].abs_id > cry_tot;
    nxt[2]  = p[1];
    nxt[2].abs_id_out = base + {1'b0, p[1].prod_mod}
                        + {{(ABS_W-CELL_W){1'b0}}, p[1].prod_row}
                        + {{(ABS_W-GRID_W){1'b0}}, p[1].column};
    if (p[1].opcode == OP_ABS_TO_REL) begin
      nxt[2].veto = is_pad;
    end
    nxt[2].rem     = is_pad ? p[1].abs_id - cry_tot - ABS_W'(1)
                            : p[1].abs_id - ABS_W'(1);
    nxt[2].div_mod = is_pad ? geom.pad_per_mod : geom.cry_per_mod;
    nxt[2].div_col = is_pad ? geom.pad_columns : geom.crystal_columns;
  end

  // stage 3: id range check, module quotient bits 3 and 2
  always_comb begin : st3
    div_t d;
    d      = div2(p[2].rem, p[2].div_mod, 3);
    nxt[3] = p[2];
    if (p[2].opcode == OP_ABS_TO_REL) begin
      nxt[3].oor = (p[2].abs_id == '0) || (p[2].abs_id > geom.all_total);
    end
    nxt[3].rem        = d.rem;
    nxt[3].q_mod[3:2] = d.q;
  end

  // stage 4: module quotient bits 1 and 0
  always_comb begin : st4
    div_t d;
    d      = div2(p[3].rem, p[3].div_mod, 1);
    nxt[4] = p[3];
    nxt[4].rem        = d.rem;
    nxt[4].q_mod[1:0] = d.q;
  end

  // stages 5 to 8: row quotient, two bits each
  for (genvar s = 5; s <= 8; s++) begin : g_row
    localparam int unsigned SH = 7 - 2 * (s - 5);
    always_comb begin : st_row
      div_t d;
      d      = div2(p[s-1].rem, {{GRID_W{1'b0}}, p[s-1].div_col}, SH);
      nxt[s] = p[s-1];
      nxt[s].rem         = d.rem;
      nxt[s].q_row[SH -: 2] = d.q;
    end
  end

  // stage 9: result fields, zero for the unused direction or out of range
  always_comb begin
    nxt[9]            = p[8];
    nxt[9].abs_id_out = '0;
    nxt[9].module_out = '0;
    nxt[9].veto_out   = 1'b0;
    nxt[9].row_out    = '0;
    nxt[9].column_out = '0;
    if (!p[8].oor) begin
      if (p[8].opcode == OP_REL_TO_ABS) begin
        nxt[9].abs_id_out = p[8].abs_id_out;
      end else begin
        nxt[9].module_out = {{(GRID_W-MOD_W){1'b0}}, p[8].q_mod} + GRID_W'(1);
        nxt[9].veto_out   = p[8].veto;
        nxt[9].row_out    = p[8].q_row + GRID_W'(1);
        nxt[9].column_out = p[8].rem[GRID_W-1:0] + GRID_W'(1);
      end
    end
  end

  // a stage takes a new item when it is empty or its item moves on
  always_comb begin
    adv[N-1] = !v[N-1] || rsp.ready;
    for (int s = N - 2; s >= 0; s--) begin
      adv[s] = !v[s] || adv[s+1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= req.valid;
      end
      for (int s = 1; s < N; s++) begin
        if (adv[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (adv[s]) begin
        p[s] <= nxt[s];
      end
    end
  end

  assign req.ready        = adv[0];
  assign rsp.valid        = v[N-1];
  assign rsp.abs_id_out   = p[N-1].abs_id_out;
  assign rsp.module_out   = p[N-1].module_out;
  assign rsp.veto_out     = p[N-1].veto_out;
  assign rsp.row_out      = p[N-1].row_out;
  assign rsp.column_out   = p[N-1].column_out;
  assign rsp.out_of_range = p[N-1].oor;

`ifndef SYNTHESIS
  // an accepted item lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v[0])
    else $error("accepted item missing from first stage");

  // requests are refused only with every stage occupied
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> &v)
    else $error("request refused with an empty stage");

  // a stalled result stays in place
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[N-1] && !rsp.ready |=> v[N-1] && $stable(p[N-1]))
    else $error("stalled result lost or changed");

  // an in-range split gives 1-based fields
  a_split_nonzero: assert property (@(posedge clk) disable iff (rst)
    v[N-1] && !p[N-1].oor && p[N-1].opcode == OP_ABS_TO_REL
      |-> rsp.module_out != '0 && rsp.row_out != '0 && rsp.column_out != '0)
    else $error("split result has a zero field");
`endif

endmodule

>>> hw/rtl/dcc_geom.sv
// ----------------------------------------------------------------------------
// dcc_geom
// Geometry registers with their products kept in registers: cells per
// module from the grid, totals per kind from those, grand total from both.
// ----------------------------------------------------------------------------
module dcc_geom (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dcc_pkg::geom_t                   geom
);
  import dcc_pkg::*;

  // register writes and products, one multiply level per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.module_count    <= MOD_W'(RST_MODULE_COUNT);
      geom.crystal_rows    <= GRID_W'(RST_CRYSTAL_ROWS);
      geom.crystal_columns <= GRID_W'(RST_CRYSTAL_COLUMNS);
      geom.pad_rows        <= GRID_W'(RST_PAD_ROWS);
      geom.pad_columns     <= GRID_W'(RST_PAD_COLUMNS);
      geom.cry_per_mod     <= CELL_W'(RST_CRY_PER_MOD);
      geom.pad_per_mod     <= CELL_W'(RST_PAD_PER_MOD);
      geom.cry_total       <= TOT_W'(RST_CRY_TOTAL);
      geom.pad_total       <= TOT_W'(RST_PAD_TOTAL);
      geom.all_total       <= ABS_W'(RST_ALL_TOTAL);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODULE_COUNT:    geom.module_count    <= cfg_data[MOD_W-1:0];
          REG_CRYSTAL_ROWS:    geom.crystal_rows    <= cfg_data;
          REG_CRYSTAL_COLUMNS: geom.crystal_columns <= cfg_data;
          REG_PAD_ROWS:        geom.pad_rows        <= cfg_data;
          REG_PAD_COLUMNS:     geom.pad_columns     <= cfg_data;
          default: ;
        endcase
      end
      // products
      geom.cry_per_mod <= {{GRID_W{1'b0}}, geom.crystal_rows}
                          * {{GRID_W{1'b0}}, geom.crystal_columns};
      geom.pad_per_mod <= {{GRID_W{1'b0}}, geom.pad_rows}
                          * {{GRID_W{1'b0}}, geom.pad_columns};
      geom.cry_total   <= {{(TOT_W-MOD_W){1'b0}}, geom.module_count}
                          * {{(TOT_W-CELL_W){1'b0}}, geom.cry_per_mod};
      geom.pad_total   <= {{(TOT_W-MOD_W){1'b0}}, geom.module_count}
                          * {{(TOT_W-CELL_W){1'b0}}, geom.pad_per_mod};
      geom.all_total   <= {1'b0, geom.cry_total} + {1'b0, geom.pad_total};
    end
  end

endmodule
